// ===== rtl/timesliced_zone_scheduler_macros.svh =====
// Assertion macros for the zone scheduler. Both sample on clk and are muted in rst.
`ifndef TIMESLICED_ZONE_SCHEDULER_MACROS_SVH
`define TIMESLICED_ZONE_SCHEDULER_MACROS_SVH

// Property that must hold at every clock edge.
`define TZS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define TZS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tzs_pkg.sv =====
`default_nettype none

package tzs_pkg;

  localparam int ZONES_DEF = 8;
  localparam int SENSORS   = 8;

  localparam int IVL_W  = 16;
  localparam int MAP_W  = 32;
  localparam int TIME_W = 32;
  localparam int WANT_W = 8;
  localparam int FZ_W   = 4;
  localparam int RZ_W   = 3;
  localparam int MASK_W = 8;
  localparam int AZ_W   = 4;
  localparam int CFG_W  = 32;
  localparam int CIDX_W = 1;

  localparam logic [IVL_W-1:0]  IVL_RESET = 16'd60;
  localparam logic [MAP_W-1:0]  MAP_RESET = 32'h7654_3210;
  localparam logic [TIME_W-1:0] MS_PER_S  = 32'd1000;
  localparam logic [TIME_W-1:0] IVL_MS_RESET = TIME_W'(IVL_RESET) * MS_PER_S;

  localparam logic [FZ_W-1:0] FZ_CLEAR = 4'hF;
  localparam logic [AZ_W-1:0] AZ_NONE  = 4'hF;

  typedef enum logic [CIDX_W-1:0] {
    REG_INTERVAL = 1'b0,
    REG_MAP      = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_FORCE  = 1'b1
  } kind_t;

endpackage

`default_nettype wire

// ===== rtl/timesliced_zone_scheduler.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// in       | in_valid / in_ready  | kind now_ms sensor_wants_water forced_zone
//          |                      | data_gathering report_zone
// out      | out_valid / out_ready| relay_mask active_zone accepted report_open_ms
// cfg      | cfg_wr_en            | cfg_index cfg_data
//
// One request per cycle sustained while out_ready holds; an accepted request reaches out through
// the input register, then the result register. The state update for a request is a single pass
// set by the elapsed-time add into the open zone's accumulator and the report mux.
// rst is synchronous and clears scheduler state, accumulators and both stages.
// A stalled out holds its result; in keeps accepting until both stages are full.
`default_nettype none

module timesliced_zone_scheduler #(
  parameter int ZONES = tzs_pkg::ZONES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [tzs_pkg::TIME_W-1:0]          now_ms,
  input  logic [tzs_pkg::WANT_W-1:0]          sensor_wants_water,
  input  logic signed [tzs_pkg::FZ_W-1:0]     forced_zone,
  input  logic                                data_gathering,
  input  logic [tzs_pkg::RZ_W-1:0]            report_zone,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tzs_pkg::MASK_W-1:0]          relay_mask,
  output logic signed [tzs_pkg::AZ_W-1:0]     active_zone,
  output logic                                accepted,
  output logic [tzs_pkg::TIME_W-1:0]          report_open_ms,
  input  logic                                cfg_wr_en,
  input  logic [tzs_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [tzs_pkg::CFG_W-1:0]           cfg_data
);
  import tzs_pkg::*;

  `include "timesliced_zone_scheduler_macros.svh"

  localparam int ZW     = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int MAPPED = (ZONES < SENSORS) ? ZONES : SENSORS;

  typedef logic [ZW-1:0] zidx_t;

  // configuration
  logic [TIME_W-1:0] interval_ms;
  logic [MAP_W-1:0]  zone_sensor_map;

  // input stage
  logic              a_valid;
  logic              a_kind;
  logic [TIME_W-1:0] a_now;
  logic [WANT_W-1:0] a_wants;
  logic [FZ_W-1:0]   a_fz;
  logic              a_gather;
  logic [RZ_W-1:0]   a_rz;
  logic              b_load;

  // scheduler state
  logic              forced_on, forced_on_next;
  zidx_t             forced_idx, forced_idx_next;
  logic              active_on, active_on_next;
  zidx_t             active_idx, active_idx_next;
  logic [TIME_W-1:0] last_switch, last_switch_next;
  logic              switch_valid, switch_valid_next;
  logic [TIME_W-1:0] last_account, last_account_next;
  logic              account_valid, account_valid_next;
  logic              valve_on, valve_on_next;
  zidx_t             valve_idx, valve_idx_next;
  logic [TIME_W-1:0] open_acc [ZONES];

  // single-pass logic
  logic [ZONES-1:0]  want;
  logic [ZONES-1:0]  above;
  logic              cur_on;
  zidx_t             cur_idx;
  logic [TIME_W-1:0] lst;
  logic [TIME_W-1:0] since;
  logic              hold;
  logic              multi;
  logic              want_cur;
  zidx_t             rr_idx;
  logic              fz_clear;
  logic              fz_pos;
  zidx_t             fz_idx;
  logic              drv;
  logic              drv_on;
  zidx_t             drv_idx;
  logic              ok;
  logic              acc_wr;
  logic [TIME_W-1:0] acc_sum;
  zidx_t             rz_idx;
  logic [TIME_W-1:0] report_next;
  logic [MASK_W-1:0] relay_next;
  logic [AZ_W-1:0]   az_next;

  function automatic zidx_t first_set(input logic [ZONES-1:0] v);
    zidx_t r;
    r = '0;
    for (int i = ZONES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = ZW'(i);
      end
    end
    return r;
  endfunction

  assign b_load   = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || b_load;

  for (genvar z = 0; z < ZONES; z++) begin : g_want
    if (z < SENSORS) begin : g_mapped
      logic [3:0] sidx;
      assign sidx    = zone_sensor_map[4*z +: 4];
      assign want[z] = (sidx < 4'(MAPPED)) && a_wants[sidx[2:0]];
    end else begin : g_unmapped
      assign want[z] = 1'b0;
    end
    assign above[z] = !cur_on || (ZW'(z) > cur_idx);
  end

  always_comb begin
    cur_on   = forced_on || active_on;
    cur_idx  = forced_on ? forced_idx : active_idx;
    lst      = switch_valid ? last_switch : a_now;
    since    = a_now - lst;
    hold     = since < interval_ms;
    multi    = |(want & (want - ZONES'(1)));
    want_cur = cur_on && want[cur_idx];
    rr_idx   = (|(want & above)) ? first_set(want & above) : first_set(want);
    fz_clear = a_fz == FZ_CLEAR;
    fz_pos   = !a_fz[FZ_W-1] && (int'(a_fz[FZ_W-2:0]) < ZONES);
    fz_idx   = ZW'(a_fz[FZ_W-2:0]);

    forced_on_next     = forced_on;
    forced_idx_next    = forced_idx;
    active_on_next     = active_on;
    active_idx_next    = active_idx;
    last_switch_next   = last_switch;
    switch_valid_next  = switch_valid;
    drv     = 1'b0;
    drv_on  = 1'b0;
    drv_idx = '0;
    ok      = 1'b1;

    if (a_kind == KIND_UPDATE) begin
      drv = 1'b1;
      if (a_gather) begin
        forced_on_next = 1'b0;
        active_on_next = 1'b0;
      end else begin
        switch_valid_next = 1'b1;
        last_switch_next  = lst;
        if (forced_on && hold) begin
          active_on_next  = 1'b1;
          active_idx_next = forced_idx;
          drv_on  = 1'b1;
          drv_idx = forced_idx;
        end else begin
          forced_on_next = 1'b0;
          if (want == '0) begin
            active_on_next = 1'b0;
          end else begin
            active_on_next = 1'b1;
            if (!want_cur || (multi && !hold)) begin
              active_idx_next  = rr_idx;
              last_switch_next = a_now;
            end else begin
              active_idx_next = cur_idx;
            end
            drv_on  = 1'b1;
            drv_idx = active_idx_next;
          end
        end
      end
    end else if (fz_clear || fz_pos) begin
      drv = 1'b1;
      forced_on_next    = fz_pos && !a_gather;
      forced_idx_next   = fz_idx;
      active_on_next    = fz_pos && !a_gather;
      active_idx_next   = fz_idx;
      switch_valid_next = fz_pos;
      last_switch_next  = fz_pos ? a_now : '0;
      drv_on  = fz_pos && !a_gather;
      drv_idx = fz_idx;
    end else begin
      ok = 1'b0;
    end

    acc_sum            = open_acc[valve_idx] + (a_now - last_account);
    acc_wr             = drv && account_valid && valve_on;
    last_account_next  = drv ? a_now : last_account;
    account_valid_next = account_valid || drv;
    valve_on_next      = drv ? drv_on : valve_on;
    valve_idx_next     = drv ? drv_idx : valve_idx;

    rz_idx = ZW'(a_rz);
    if (int'(a_rz) >= ZONES) begin
      report_next = '0;
    end else if (acc_wr && (rz_idx == valve_idx)) begin
      report_next = acc_sum;
    end else begin
      report_next = open_acc[rz_idx];
    end

    relay_next = (valve_on_next && (int'(valve_idx_next) < MASK_W)) ?
                 (MASK_W'(1) << valve_idx_next) : '0;
    az_next    = active_on_next ? AZ_W'(active_idx_next) : AZ_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms     <= IVL_MS_RESET;
      zone_sensor_map <= MAP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_INTERVAL: interval_ms     <= TIME_W'(cfg_data[IVL_W-1:0]) * MS_PER_S;
        REG_MAP:      zone_sensor_map <= cfg_data[MAP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_kind   <= kind;
      a_now    <= now_ms;
      a_wants  <= sensor_wants_water;
      a_fz     <= forced_zone;
      a_gather <= data_gathering;
      a_rz     <= report_zone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forced_on     <= 1'b0;
      forced_idx    <= '0;
      active_on     <= 1'b0;
      active_idx    <= '0;
      last_switch   <= '0;
      switch_valid  <= 1'b0;
      last_account  <= '0;
      account_valid <= 1'b0;
      valve_on      <= 1'b0;
      valve_idx     <= '0;
      for (int z = 0; z < ZONES; z++) begin
        open_acc[z] <= '0;
      end
    end else if (b_load) begin
      forced_on     <= forced_on_next;
      forced_idx    <= forced_idx_next;
      active_on     <= active_on_next;
      active_idx    <= active_idx_next;
      last_switch   <= last_switch_next;
      switch_valid  <= switch_valid_next;
      last_account  <= last_account_next;
      account_valid <= account_valid_next;
      valve_on      <= valve_on_next;
      valve_idx     <= valve_idx_next;
      if (acc_wr) begin
        open_acc[valve_idx] <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      relay_mask     <= relay_next;
      active_zone    <= az_next;
      accepted       <= ok;
      report_open_ms <= report_next;
    end
  end

  `TZS_ASSERT(a_valve_tracks_active, (valve_on == active_on) && (!valve_on || (valve_idx == active_idx)), "open valve differs from active zone")
  `TZS_ASSERT(a_forced_is_active, !forced_on || (active_on && (active_idx == forced_idx)), "forced zone is not the active zone")
  `TZS_ASSERT(a_relay_onehot, !out_valid || $onehot0(relay_mask), "more than one valve open")
  `TZS_ASSERT_NEXT(a_update_accepted, b_load && (a_kind == KIND_UPDATE), out_valid && accepted, "update request not accepted")

endmodule

`default_nettype wire
